// ===== design/gbim_pkg.sv =====
// ----------------------------------------------------------------------------
// gbim_pkg
// shared types, microcode codes and the control store of the base (-1+i)
// converter
// ----------------------------------------------------------------------------
package gbim_pkg;

    // working width of the real and imaginary registers
    localparam int DP_W = 18;

    // input item fields
    localparam int IN_W = 16;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_cond;
    typedef logic [1:0] t_step;

    // datapath operations
    localparam t_op OP_LOAD  = 2'd0;
    localparam t_op OP_ROUND = 2'd1;
    localparam t_op OP_ZFIX  = 2'd2;
    localparam t_op OP_EMIT  = 2'd3;

    // jump conditions
    localparam t_cond C_ALWAYS   = 2'd0;
    localparam t_cond C_IN_ACC   = 2'd1;
    localparam t_cond C_DONE     = 2'd2;
    localparam t_cond C_POP_LAST = 2'd3;

    // program steps
    localparam t_step S_WAIT  = 2'd0;
    localparam t_step S_ROUND = 2'd1;
    localparam t_step S_ZFIX  = 2'd2;
    localparam t_step S_EMIT  = 2'd3;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jmp;   // taken when cond holds
        t_step nxt;   // taken otherwise
    } t_uword;

    typedef struct packed {
        t_op op;
    } t_ctrl;

    typedef struct packed {
        logic in_acc;
        logic done;
        logic pop_last;
    } t_stat;

    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        case (step)
            S_WAIT:  w = '{op: OP_LOAD,  cond: C_IN_ACC,   jmp: S_ROUND, nxt: S_WAIT};
            S_ROUND: w = '{op: OP_ROUND, cond: C_DONE,     jmp: S_ZFIX,  nxt: S_ROUND};
            S_ZFIX:  w = '{op: OP_ZFIX,  cond: C_ALWAYS,   jmp: S_EMIT,  nxt: S_EMIT};
            S_EMIT:  w = '{op: OP_EMIT,  cond: C_POP_LAST, jmp: S_WAIT,  nxt: S_EMIT};
            default: w = '{op: OP_LOAD,  cond: C_IN_ACC,   jmp: S_ROUND, nxt: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== design/gaussian_int_to_base_i_minus_one.sv =====
// ----------------------------------------------------------------------------
// gaussian_int_to_base_i_minus_one
// converts a gaussian integer to its base (-1+i) digits, most significant
// first, one digit per output item
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser  tlast
//  s_       in   [15:0] real_part, [31:16] imag_part     -      -
//  m_       out  [0] digit, [7:1] zero                   -      last
//
//  an item with n digits is loaded, takes one round per digit on the shared
//  divide-by-(-1+i) datapath, then the zero-input fixup, then pops the
//  digit stack one digit per cycle while m_ does not stall; a zero input
//  gives a single digit
//  s_tready is high only while the program waits at its first step
//  m_ backpressure holds the pop step; the output register lets the next
//  item load while the final digit still waits
//  reset clears the step counter, digit count and output valid
// ----------------------------------------------------------------------------
module gaussian_int_to_base_i_minus_one
    import gbim_pkg::*;
#(
    parameter int MAX_DIGITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] real_part, [31:16] imag_part
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] digit, [7:1] zero
    output logic        m_tlast
);

    t_ctrl w_ctrl;
    t_stat w_stat;
    logic  w_digit;

    gbim_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    gbim_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .o_stat     (w_stat),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_digit  (w_digit),
        .o_m_last   (m_tlast)
    );

    assign m_tdata = {7'b0, w_digit};

endmodule

// ===== design/gbim_seq.sv =====
// ----------------------------------------------------------------------------
// gbim_seq
// step counter and control store; evaluates the jump condition of each
// control word against datapath status
// ----------------------------------------------------------------------------
module gbim_seq
    import gbim_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_cond;

    assign w_word = uc_rom(r_step);

    always_comb begin
        case (w_word.cond)
            C_ALWAYS:   w_cond = 1'b1;
            C_IN_ACC:   w_cond = i_stat.in_acc;
            C_DONE:     w_cond = i_stat.done;
            C_POP_LAST: w_cond = i_stat.pop_last;
            default:    w_cond = 1'b0;
        endcase
        n_step = w_cond ? w_word.jmp : w_word.nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.op = w_word.op;

endmodule

// ===== design/gbim_dp.sv =====
// ----------------------------------------------------------------------------
// gbim_dp
// datapath: real/imag registers with the divide-by-(-1+i) round, a digit
// stack that reverses the order, and the output register
// ----------------------------------------------------------------------------
module gbim_dp
    import gbim_pkg::*;
#(
    parameter int MAX_DIGITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    output t_stat                o_stat,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [2*IN_W-1:0]    i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic                 o_m_digit,
    output logic                 o_m_last
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic signed [DP_W-1:0] r_a;
    logic signed [DP_W-1:0] r_b;
    logic [MAX_DIGITS-1:0]  r_stk;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_out_valid;
    logic                   r_out_digit;
    logic                   r_out_last;

    logic                   w_d;
    logic signed [DP_W:0]   w_a1;
    logic signed [DP_W:0]   w_bx;
    logic signed [DP_W:0]   w_s;
    logic signed [DP_W:0]   w_t;
    logic signed [DP_W:0]   w_na;
    logic signed [DP_W:0]   w_nb;
    logic                   w_in_acc;
    logic                   w_done;
    logic                   w_load;
    logic                   w_round;
    logic                   w_zfix;
    logic                   w_emit;
    logic                   w_cnt_one;

    assign o_s_tready = (i_ctrl.op == OP_LOAD);
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    // digit, then exact division by (-1+i): a' = -(a-d-b)/2, b' = -(a-d+b)/2
    assign w_d  = r_a[0] ^ r_b[0];
    assign w_a1 = {r_a[DP_W-1], r_a} - {{DP_W{1'b0}}, w_d};
    assign w_bx = {r_b[DP_W-1], r_b};
    assign w_s  = w_a1 - w_bx;
    assign w_t  = w_a1 + w_bx;
    assign w_na = -(w_s >>> 1);
    assign w_nb = -(w_t >>> 1);

    assign w_done    = ((r_a == '0) && (r_b == '0)) || (r_cnt == CNT_W'(MAX_DIGITS));
    assign w_cnt_one = (r_cnt == CNT_W'(1));

    assign w_load  = (i_ctrl.op == OP_LOAD) && w_in_acc;
    assign w_round = (i_ctrl.op == OP_ROUND) && !w_done;
    assign w_zfix  = (i_ctrl.op == OP_ZFIX) && (r_cnt == '0);
    assign w_emit  = (i_ctrl.op == OP_EMIT) && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_a <= {{(DP_W-IN_W){i_s_tdata[IN_W-1]}}, i_s_tdata[IN_W-1:0]};
            r_b <= {{(DP_W-IN_W){i_s_tdata[2*IN_W-1]}}, i_s_tdata[2*IN_W-1:IN_W]};
        end else if (w_round) begin
            r_a <= w_na[DP_W-1:0];
            r_b <= w_nb[DP_W-1:0];
        end
    end

    // stack top sits at bit 0
    always_ff @(posedge i_clk) begin
        if (w_round) begin
            r_stk <= {r_stk[MAX_DIGITS-2:0], w_d};
        end else if (w_zfix) begin
            r_stk <= {r_stk[MAX_DIGITS-2:0], 1'b0};
        end else if (w_emit) begin
            r_stk <= {1'b0, r_stk[MAX_DIGITS-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_load) begin
            r_cnt <= '0;
        end else if (w_round || w_zfix) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (w_emit) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_digit <= r_stk[0];
            r_out_last  <= w_cnt_one;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_digit  = r_out_digit;
    assign o_m_last   = r_out_last;

    assign o_stat.in_acc   = w_in_acc;
    assign o_stat.done     = w_done;
    assign o_stat.pop_last = w_emit && w_cnt_one;

endmodule

// ===== design/gbim_chk.sv =====
// ----------------------------------------------------------------------------
// gbim_chk
// port-level checks for the base (-1+i) converter, bound to the top level
// ----------------------------------------------------------------------------
module gbim_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // a stalled output item keeps its valid
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped under stall");

    // a stalled output item keeps its payload
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed under stall");

    // an accepted item starts conversion, so input closes at once
    a_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready stayed high after an accepted item");

    // while a non-final digit waits, the conversion is still running
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready while digits of the previous item pend");

    // upper bits of the output word stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("output padding bits set");

endmodule

bind gaussian_int_to_base_i_minus_one gbim_chk u_gbim_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
